>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true at an edge implies the consequent at the same edge.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Antecedent true at an edge implies the consequent at the next edge.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

>>> hw/rtl/rmeu_pkg.sv
package rmeu_pkg;

  // Instruction opcodes as the decoder numbers them.
  typedef enum logic [4:0] {
    OP_EXIT  = 5'd1,
    OP_MOVE  = 5'd2,
    OP_ADD   = 5'd3,
    OP_SUB   = 5'd4,
    OP_MULT  = 5'd5,
    OP_DIV   = 5'd6,
    OP_SHL   = 5'd7,
    OP_SHR   = 5'd8,
    OP_AND   = 5'd9,
    OP_OR    = 5'd10,
    OP_XOR   = 5'd11,
    OP_NOT   = 5'd12,
    OP_PRINT = 5'd13,
    OP_JMPZ  = 5'd14,
    OP_RELZ  = 5'd15,
    OP_JMPNZ = 5'd16,
    OP_RELNZ = 5'd17,
    OP_SWAP  = 5'd18,
    OP_PUSH  = 5'd19,
    OP_POP   = 5'd20,
    OP_CALL  = 5'd21,
    OP_RET   = 5'd22
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_EXEC  = 2'd0,
    KIND_PRINT = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_FAULT = 2'd3
  } kind_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage

>>> hw/rtl/register_machine_execute_unit.sv
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+----------------------------------------
// command  | in        | cmd_valid / cmd_stall      | cmd, operand_count, opN_is_reg/value
// result   | out       | result_valid / result_stall| result_kind, result_value, last_result
//
// An instruction runs from one command transfer to the next through the states check, a
// read and an accumulate state per operand read, execute, emit and idle. Folding add, sub,
// and, or and xor passes through execute again per folded operand; swap adds a second write
// state, pop and ret a stack read state, and a print one emit per extra result. Each multiply
// or divide step runs through the shared serial unit.
// Reset is synchronous and clears the pc, sp and register valid bits; the stack memory holds
// garbage until written, and the pointer's low bits address it, so the user must keep its
// depth a power of two; the block itself leaves this unchecked. The next command is taken
// while the last result is held, and its first result waits until the register is free.
module register_machine_execute_unit #(
  parameter int NUM_REGS     = 16,
  parameter int STACK_DEPTH  = 64,
  parameter int MAX_OPERANDS = 3,
  parameter int DATA_WIDTH   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [4:0]  cmd,
  input  logic [1:0]  operand_count,
  input  logic        op0_is_reg,
  input  logic [63:0] op0_value,
  input  logic        op1_is_reg,
  input  logic [63:0] op1_value,
  input  logic        op2_is_reg,
  input  logic [63:0] op2_value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  result_kind,
  output logic [63:0] result_value,
  output logic        last_result
);
  import rmeu_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int RW  = $clog2(NUM_REGS);
  localparam int SAW = $clog2(STACK_DEPTH);

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_RD    = 9'b000000100,
    S_ACC   = 9'b000001000,
    S_EXEC  = 9'b000010000,
    S_ALU   = 9'b000100000,
    S_STK   = 9'b001000000,
    S_WB1   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t        state;
  opcode_t       op_q;
  logic [1:0]    cnt_q;
  logic [2:0]    isr_q;
  logic [63:0]   val_q [3];
  logic [W-1:0]  opv [3];
  logic [1:0]    idx;
  logic [1:0]    nread_q;
  logic [W-1:0]  a_q;
  logic [W-1:0]  pc;
  logic [W-1:0]  sp;
  logic [W-1:0]  sp_inc;
  kind_t         ekind;

  // General registers 2 and up live in a memory; 0 and 1 are the pc and sp flops.
  logic [W-1:0]        regs [NUM_REGS];
  logic [NUM_REGS-1:0] rv;
  logic [W-1:0]        rd_q;
  logic                rv_q;

  logic [W-1:0]   stk [STACK_DEPTH];
  logic [W-1:0]   stk_q;
  logic [SAW-1:0] stk_addr;

  alu_ctl_t     actl;
  alu_sts_t     asts;
  logic [W-1:0] alu_a;
  logic [W-1:0] alu_b;
  logic [W-1:0] alu_y;

  logic [W-1:0] cur_val;
  logic         alias_dst;
  logic [W-1:0] b_op;
  logic [W-1:0] shift_res;
  logic [W-1:0] rel_off;
  logic         zero0;
  logic [2:0]   need;
  logic [1:0]   cnt_in;
  logic         is_multi;

  logic         wr_en;
  logic         wr_op;
  logic [W-1:0] wr_data;
  logic         wr_reg;
  logic         pc_ld;
  logic [W-1:0] pc_d;
  logic         sp_ld;
  logic [W-1:0] sp_d;
  logic         stk_we;
  logic [W-1:0] stk_wdata;
  logic         stk_re;
  logic         emit_ok;
  logic         emit_last;

  // Returns {known opcode, operands needed}.
  function automatic logic [2:0] need_of(opcode_t c);
    logic [2:0] v;
    unique case (c)
      OP_MOVE, OP_SHL, OP_SHR, OP_JMPZ, OP_RELZ, OP_JMPNZ, OP_RELNZ,
      OP_SWAP: v = 3'b110;
      OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_AND, OP_OR, OP_XOR, OP_NOT,
      OP_PUSH, OP_POP, OP_CALL: v = 3'b101;
      OP_EXIT, OP_PRINT, OP_RET: v = 3'b100;
      default: v = 3'b000;
    endcase
    return v;
  endfunction

  // Number of operands whose values the instruction reads before it executes.
  function automatic logic [1:0] nread_of(opcode_t c, logic [1:0] n);
    logic [1:0] v;
    unique case (c)
      OP_MOVE, OP_SHL, OP_SHR, OP_SWAP: v = 2'd2;
      OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_AND, OP_OR, OP_XOR, OP_PRINT: v = n;
      OP_NOT, OP_JMPZ, OP_RELZ, OP_JMPNZ, OP_RELNZ, OP_PUSH, OP_CALL: v = 2'd1;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

  // Operands past the configured maximum are ignored.
  assign cnt_in = (MAX_OPERANDS < 3 && operand_count > 2'(MAX_OPERANDS)) ?
                  2'(MAX_OPERANDS) : operand_count;
  assign need   = need_of(op_q);

  assign is_multi = (op_q == OP_ADD) || (op_q == OP_SUB) || (op_q == OP_MULT) ||
                    (op_q == OP_DIV) || (op_q == OP_AND) || (op_q == OP_OR) ||
                    (op_q == OP_XOR);

  // Value of the operand being fetched. Register numbers past the file read as zero.
  always_comb begin
    if (!isr_q[idx]) begin
      cur_val = val_q[idx][W-1:0];
    end else if (val_q[idx] == 64'd0) begin
      cur_val = pc;
    end else if (val_q[idx] == 64'd1) begin
      cur_val = sp;
    end else if (val_q[idx] < 64'(NUM_REGS) && rv_q) begin
      cur_val = rd_q;
    end else begin
      cur_val = '0;
    end
  end

  // A source naming the destination register sees the running value.
  assign alias_dst = isr_q[0] && isr_q[idx] && (val_q[0] == val_q[idx]);
  assign b_op      = alias_dst ? a_q : opv[idx];

  always_comb begin
    if (opv[1] < W'(W)) begin
      shift_res = (op_q == OP_SHL) ? (opv[0] << opv[1]) : (opv[0] >> opv[1]);
    end else begin
      shift_res = '0;
    end
  end

  // A negative relative offset steps back one further.
  assign rel_off = val_q[1][W-1] ? (val_q[1][W-1:0] - W'(1)) : val_q[1][W-1:0];
  assign zero0   = (opv[0] == '0);

  // Push and call store at the incremented pointer, pop and ret read at the current one.
  assign sp_inc   = sp + W'(1);
  assign stk_addr = (op_q == OP_PUSH || op_q == OP_CALL) ? sp_inc[SAW-1:0] : sp[SAW-1:0];

  // Architectural write requests of the current step.
  always_comb begin
    wr_en     = 1'b0;
    wr_op     = 1'b0;
    wr_data   = '0;
    pc_ld     = 1'b0;
    pc_d      = '0;
    sp_ld     = 1'b0;
    sp_d      = '0;
    stk_we    = 1'b0;
    stk_wdata = (op_q == OP_PUSH) ? opv[0] : pc;
    stk_re    = 1'b0;
    actl      = '0;
    alu_a     = a_q;
    alu_b     = b_op;
    priority case (1'b1)
      state == S_EXEC: begin
        if (is_multi && idx >= cnt_q) begin
          wr_en   = 1'b1;
          wr_data = a_q;
        end else if (op_q == OP_MULT) begin
          actl.start = 1'b1;
          actl.op    = ALU_MUL;
        end else if (op_q == OP_DIV) begin
          actl.start = (b_op != '0);
          actl.op    = ALU_DIV;
        end else if (op_q == OP_MOVE || op_q == OP_SWAP) begin
          wr_en   = 1'b1;
          wr_data = opv[1];
        end else if (op_q == OP_SHL || op_q == OP_SHR) begin
          wr_en   = 1'b1;
          wr_data = shift_res;
        end else if (op_q == OP_NOT) begin
          wr_en   = 1'b1;
          wr_data = ~opv[0];
        end else if (op_q == OP_JMPZ || op_q == OP_JMPNZ) begin
          pc_ld = (zero0 == (op_q == OP_JMPZ));
          pc_d  = val_q[1][W-1:0];
        end else if (op_q == OP_RELZ || op_q == OP_RELNZ) begin
          pc_ld = (zero0 == (op_q == OP_RELZ));
          pc_d  = pc + rel_off;
        end else if (op_q == OP_PUSH || op_q == OP_CALL) begin
          stk_we = 1'b1;
          sp_ld  = 1'b1;
          sp_d   = sp_inc;
          pc_ld  = (op_q == OP_CALL);
          // The call target is read after the push has moved the stack pointer.
          pc_d   = (isr_q[0] && val_q[0] == 64'd1) ? sp_inc : opv[0];
        end else if (op_q == OP_POP || op_q == OP_RET) begin
          stk_re = 1'b1;
        end
      end
      state == S_STK: begin
        wr_en   = (op_q == OP_POP);
        wr_data = stk_q;
        pc_ld   = (op_q == OP_RET);
        pc_d    = stk_q;
        sp_ld   = 1'b1;
        sp_d    = sp - W'(1);
      end
      state == S_WB1: begin
        wr_en   = 1'b1;
        wr_op   = 1'b1;
        wr_data = opv[0];
      end
      default: begin
      end
    endcase
  end

  assign wr_reg = wr_en && isr_q[wr_op] && (val_q[wr_op] > 64'd1) &&
                  (val_q[wr_op] < 64'(NUM_REGS));

  assign emit_ok   = !result_valid || !result_stall;
  assign emit_last = (ekind != KIND_PRINT) || (idx == 2'(cnt_q - 2'd1));
  assign cmd_stall = (state != S_IDLE);

  rmeu_alu #(
    .AW(W)
  ) u_alu (
    .clk (clk),
    .rst (rst),
    .ctl (actl),
    .a   (alu_a),
    .b   (alu_b),
    .sts (asts),
    .y   (alu_y)
  );

  // Register memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_reg) begin
      regs[val_q[wr_op][RW-1:0]] <= wr_data;
    end
    if (state == S_RD) begin
      rd_q <= regs[val_q[idx][RW-1:0]];
    end
  end

  // Stack memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_addr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q <= stk[stk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pc           <= '0;
      sp           <= '0;
      rv           <= '0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      // The emit state refills the result register itself.
      if (result_valid && !result_stall && state != S_EMIT) begin
        result_valid <= 1'b0;
      end

      // Explicit pc and sp loads win over a write of the destination.
      if (pc_ld) begin
        pc <= pc_d;
      end else if (wr_en && isr_q[wr_op] && val_q[wr_op] == 64'd0) begin
        pc <= wr_data;
      end
      if (sp_ld) begin
        sp <= sp_d;
      end else if (wr_en && isr_q[wr_op] && val_q[wr_op] == 64'd1) begin
        sp <= wr_data;
      end
      if (wr_reg) begin
        rv[val_q[wr_op][RW-1:0]] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op_q     <= opcode_t'(cmd);
            cnt_q    <= cnt_in;
            isr_q    <= {op2_is_reg, op1_is_reg, op0_is_reg};
            val_q[0] <= op0_value;
            val_q[1] <= op1_value;
            val_q[2] <= op2_value;
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          idx     <= '0;
          nread_q <= nread_of(op_q, cnt_q);
          if (!need[2] || cnt_q < need[1:0]) begin
            ekind <= KIND_FAULT;
            state <= S_EMIT;
          end else if (nread_of(op_q, cnt_q) == 2'd0) begin
            state <= S_EXEC;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: begin
          rv_q  <= rv[val_q[idx][RW-1:0]];
          state <= S_ACC;
        end
        S_ACC: begin
          opv[idx] <= cur_val;
          if (idx == 2'd0) begin
            a_q <= cur_val;
          end
          if (idx == 2'(nread_q - 2'd1)) begin
            idx   <= 2'd1;
            state <= S_EXEC;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_RD;
          end
        end
        S_EXEC: begin
          if (is_multi && idx >= cnt_q) begin
            ekind <= KIND_EXEC;
            state <= S_EMIT;
          end else if (is_multi) begin
            unique case (op_q)
              OP_ADD:  a_q <= a_q + b_op;
              OP_SUB:  a_q <= a_q - b_op;
              OP_AND:  a_q <= a_q & b_op;
              OP_OR:   a_q <= a_q | b_op;
              OP_XOR:  a_q <= a_q ^ b_op;
              default: begin
              end
            endcase
            if (op_q == OP_MULT) begin
              state <= S_ALU;
            end else if (op_q == OP_DIV) begin
              // A zero divisor abandons the instruction before any write.
              if (b_op == '0) begin
                ekind <= KIND_FAULT;
                state <= S_EMIT;
              end else begin
                state <= S_ALU;
              end
            end else begin
              idx <= idx + 2'd1;
            end
          end else begin
            unique case (op_q)
              OP_PRINT: begin
                ekind <= (cnt_q == 2'd0) ? KIND_EMPTY : KIND_PRINT;
                idx   <= '0;
                state <= S_EMIT;
              end
              OP_SWAP: begin
                ekind <= KIND_EXEC;
                state <= S_WB1;
              end
              OP_POP, OP_RET: begin
                ekind <= KIND_EXEC;
                state <= S_STK;
              end
              default: begin
                ekind <= KIND_EXEC;
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_ALU: begin
          if (asts.done) begin
            a_q   <= alu_y;
            idx   <= idx + 2'd1;
            state <= S_EXEC;
          end
        end
        S_STK: begin
          state <= S_EMIT;
        end
        S_WB1: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_ok) begin
            result_valid <= 1'b1;
            result_kind  <= ekind;
            result_value <= (ekind == KIND_PRINT) ? 64'(opv[idx]) : 64'(pc);
            last_result  <= emit_last;
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/rmeu_alu.sv
// Bit-serial multiply (shift and add) and restoring divide, one bit per cycle.
module rmeu_alu #(
  parameter int AW = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  rmeu_pkg::alu_ctl_t ctl,
  input  logic [AW-1:0]      a,
  input  logic [AW-1:0]      b,
  output rmeu_pkg::alu_sts_t sts,
  output logic [AW-1:0]      y
);
  import rmeu_pkg::*;

  localparam int CW = $clog2(AW + 1);

  logic [CW-1:0] n;
  alu_op_t       op_q;
  logic [AW-1:0] x;
  logic [AW-1:0] d;
  logic [AW-1:0] acc;
  logic [AW:0]   rem;
  logic [AW:0]   trial;

  // Next partial remainder with the following dividend bit shifted in.
  assign trial = {rem[AW-1:0], x[AW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      sts <= '0;
      n   <= '0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        op_q     <= ctl.op;
        x        <= a;
        d        <= b;
        acc      <= '0;
        rem      <= '0;
        n        <= CW'(AW);
        sts.busy <= 1'b1;
      end else if (sts.busy) begin
        if (op_q == ALU_MUL) begin
          if (x[0]) begin
            acc <= acc + d;
          end
          d <= d << 1;
          x <= x >> 1;
        end else begin
          // The quotient bits fill x from the bottom as the dividend leaves it.
          if (trial >= {1'b0, d}) begin
            rem <= trial - {1'b0, d};
            x   <= {x[AW-2:0], 1'b1};
          end else begin
            rem <= trial;
            x   <= {x[AW-2:0], 1'b0};
          end
        end
        n <= n - CW'(1);
        if (n == CW'(1)) begin
          sts.busy <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  assign y = (op_q == ALU_MUL) ? acc : x;

endmodule

>>> hw/rtl/rmeu_checker.sv
`include "assert_macros.svh"

module rmeu_assertions (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  result_kind,
  input logic [63:0] result_value,
  input logic        last_result
);
  import rmeu_pkg::*;

  // A held result keeps its value.
  `CHK_NEXT(a_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result_value))
  // An accepted command occupies the unit in the following cycle.
  `CHK_NEXT(a_busy, clk, rst, cmd_valid && !cmd_stall, cmd_stall)
  // A fault is always the sole result of its instruction.
  `CHK_IMPLY(a_fault, clk, rst, result_valid && result_kind == KIND_FAULT, last_result)
  // An executed or empty-print result also closes its instruction.
  `CHK_IMPLY(a_single, clk, rst, result_valid && (result_kind == KIND_EXEC || result_kind == KIND_EMPTY), last_result)

endmodule

bind register_machine_execute_unit rmeu_assertions u_rmeu_assertions (.*);
